FILE: hw/rtl/ipdr_pkg.sv
// Shared types and constants for the IP destination rewrite block.
// No dependencies; imported by ip_destination_rewrite.
package ipdr_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        end_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  out_valid_bytes;
    logic        out_end_of_frame;
  } out_beat_t;

  // register map, index = paddr[2]
  localparam logic RegXorKey    = 1'b0;
  localparam logic RegEthertype = 1'b1;

  localparam logic [7:0]  XorKeyReset    = 8'hAA;
  localparam logic [15:0] EthertypeReset = 16'h0800;

  // byte counts within the held header (max 4*19 = 76)
  localparam int unsigned ByteCntW = 7;
  localparam logic [ByteCntW-1:0] EtherEndBytes = 7'd14;  // ethertype complete
  localparam logic [ByteCntW-1:0] IhlEndBytes   = 7'd15;  // version/IHL byte seen
  localparam logic [ByteCntW-1:0] MinNeedBytes  = 7'd38;  // hidden bytes complete

  // word slots of interest (4 bytes per word)
  localparam int unsigned WordEthIhl  = 3;  // bytes 12..15
  localparam int unsigned WordCsum    = 6;  // bytes 24..27, checksum in high half
  localparam int unsigned WordDstHi   = 7;  // bytes 28..31, dst hi in low half
  localparam int unsigned WordDstLo   = 8;  // bytes 32..35, dst lo high, hidden lo
  localparam int unsigned WordHidden  = 9;  // bytes 36..39, hidden hi in high half

  // raw ones-complement accumulator: up to 32 halfwords
  localparam int unsigned AccW = 21;

endpackage

FILE: hw/rtl/ipdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the buffered header words.
module ipdr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 19
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ip_destination_rewrite.sv
// IPv4 destination rewrite with header checksum update, top level.
// Depends on ipdr_pkg and ipdr_ram.
//
// Flow: header words are taken one per cycle into the hold RAM. A rewritten
// frame then passes the StSum and StFold checksum states, and the n held words
// leave from the RAM, whose read data is registered, one per cycle while the
// output is not stalled. Pass-through beats move one per cycle while not stalled.
// Reset: async active-low; clears control state, config returns to key 0xAA
// and ethertype 0x0800. The hold RAM needs no clearing pass.
module ip_destination_rewrite
  import ipdr_pkg::*;
#(
  parameter int unsigned HOLD_WORDS = 19
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_beat_t   in_beat_i,
  // output stream
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_beat_t  out_beat_o,
  // APB config
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam int unsigned AW = $clog2(HOLD_WORDS);
  localparam int unsigned CW = $clog2(HOLD_WORDS + 1);
  localparam logic [ByteCntW-1:0] HoldBytes = ByteCntW'(4 * HOLD_WORDS);

  // sequencer states
  localparam logic [2:0] StHold = 3'd0;  // collecting header words
  localparam logic [2:0] StSum  = 3'd1;  // add rewritten address halves
  localparam logic [2:0] StFold = 3'd2;  // end-around fold, invert
  localparam logic [2:0] StRel  = 3'd3;  // drain hold RAM
  localparam logic [2:0] StPass = 3'd4;  // rest of frame flows through

  logic [2:0] state_q, state_d;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [7:0]  xor_key_q;
  logic [15:0] match_et_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_key_q  <= XorKeyReset;
      match_et_q <= EthertypeReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegXorKey:    xor_key_q  <= pwdata[7:0];
        RegEthertype: match_et_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegXorKey:    prdata = {24'b0, xor_key_q};
      RegEthertype: prdata = {16'b0, match_et_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control and payload registers
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   cnt_q, cnt_d;        // words held
  logic [CW-1:0]   rd_ptr_q, rd_ptr_d;  // next RAM read
  logic [CW-1:0]   rd_idx_q;            // index of word in RAM read data
  logic            rd_pend_q, rd_pend_d;
  logic            ovalid_q, ovalid_d;
  out_beat_t       obeat_q, obeat_d;
  logic            eof_q;               // frame ended in held words
  logic [2:0]      vb_q;                // byte count of that last beat
  logic            rew_q;               // header gets rewritten
  logic [23:0]     hdr_q;               // bytes 12..14
  logic [15:0]     x34_q, x36_q;        // hidden address halves
  logic [AccW-1:0] acc_q, acc_d;
  logic [15:0]     csum_q;

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  logic        can_load, in_fire, hold_fire, pass_fire;
  logic [31:0] w;
  logic [2:0]  vbn;
  logic        eof;

  assign can_load   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == StHold) || ((state_q == StPass) && can_load);
  assign in_fire    = in_valid_i && in_ready_o;
  assign hold_fire  = in_fire && (state_q == StHold);
  assign pass_fire  = in_fire && (state_q == StPass);

  assign w   = in_beat_i.data_word;
  assign eof = in_beat_i.end_of_frame;
  // inner beats always count as full; bad counts read as four
  assign vbn = (!eof || in_beat_i.valid_bytes == 3'd0 || in_beat_i.valid_bytes > 3'd4)
               ? 3'd4 : in_beat_i.valid_bytes;

  // release decision for a beat taken while holding
  logic                is3;
  logic [ByteCntW-1:0] nbytes, need_raw, need;
  logic [15:0]         et;
  logic [3:0]          ihl;
  logic                mismatch, ihl_bad, too_long, have_all, c15;
  logic                rel_now, rew_now;

  assign is3      = (cnt_q == CW'(WordEthIhl));
  assign nbytes   = ByteCntW'({cnt_q, 2'b00}) + ByteCntW'(vbn);
  assign et       = is3 ? w[31:16] : hdr_q[23:8];
  assign ihl      = is3 ? w[11:8]  : hdr_q[3:0];
  assign need_raw = EtherEndBytes + ByteCntW'({ihl, 2'b00});
  assign need     = (need_raw < MinNeedBytes) ? MinNeedBytes : need_raw;
  assign c15      = (nbytes >= IhlEndBytes);
  assign mismatch = (nbytes >= EtherEndBytes) && (et != match_et_q);
  assign ihl_bad  = ihl < 4'd5;
  assign too_long = need > HoldBytes;
  assign have_all = nbytes >= need;
  assign rew_now  = !mismatch && c15 && !ihl_bad && !too_long && have_all;
  assign rel_now  = mismatch || (c15 && (ihl_bad || too_long || have_all)) || eof
                    || ((cnt_q + CW'(1)) >= CW'(HOLD_WORDS));

  // running checksum: halfwords of header bytes 14..13+4*IHL, leaving out the
  // checksum field and the destination; the rewritten destination is added in StSum
  logic [5:0]  idx6, ihl6;
  logic        inc_hi, inc_lo;
  logic [16:0] add17;

  assign idx6   = 6'(cnt_q);
  assign ihl6   = 6'(hdr_q[3:0]);
  assign inc_lo = is3 || ((idx6 >= 6'd4) && (idx6 <= ihl6 + 6'd2)
                          && (idx6 != 6'(WordDstHi)));
  assign inc_hi = (idx6 >= 6'd4) && (idx6 <= ihl6 + 6'd3)
                  && (idx6 != 6'(WordCsum)) && (idx6 != 6'(WordDstLo));
  assign add17  = (inc_hi ? 17'(w[31:16]) : 17'd0) + (inc_lo ? 17'(w[15:0]) : 17'd0);

  logic [15:0] kk;
  assign kk = {xor_key_q, xor_key_q};

  logic [16:0] fold1;
  logic [15:0] fold2;
  assign fold1 = 17'(acc_q[15:0]) + 17'(acc_q[AccW-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  // ---------------------------------------------------------------------------
  // Hold RAM and drain
  // ---------------------------------------------------------------------------
  logic        rd_issue, rd_load;
  logic [31:0] rdata, pword;
  logic        rd_last;

  assign rd_issue = (state_q == StRel) && (rd_ptr_q != cnt_q) && (!rd_pend_q || can_load);
  assign rd_load  = rd_pend_q && can_load;

  ipdr_ram #(
    .Width (32),
    .Depth (HOLD_WORDS)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (hold_fire),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (w),
    .re_i    (rd_issue),
    .raddr_i (rd_ptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // patch checksum and destination on the way out
  always_comb begin
    pword = rdata;
    if (rew_q) begin
      if (rd_idx_q == CW'(WordCsum))  pword[31:16] = csum_q;
      if (rd_idx_q == CW'(WordDstHi)) pword[15:0]  = x34_q ^ kk;
      if (rd_idx_q == CW'(WordDstLo)) pword[31:16] = x36_q ^ kk;
    end
  end

  assign rd_last = eof_q && ((rd_idx_q + CW'(1)) == cnt_q);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_ptr_d  = rd_ptr_q;
    rd_pend_d = rd_pend_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    obeat_d   = obeat_q;
    acc_d     = acc_q;

    unique case (state_q)
      StHold: begin
        if (hold_fire) begin
          cnt_d = cnt_q + CW'(1);
          acc_d = ((cnt_q == '0) ? '0 : acc_q) + AccW'(add17);
          if (rel_now) begin
            rd_ptr_d  = '0;
            rd_pend_d = 1'b0;
            state_d   = rew_now ? StSum : StRel;
          end
        end
      end
      StSum: begin
        acc_d   = acc_q + AccW'(x34_q ^ kk) + AccW'(x36_q ^ kk);
        state_d = StFold;
      end
      StFold: begin
        state_d = StRel;
      end
      StRel: begin
        if (rd_load) begin
          ovalid_d = 1'b1;
          obeat_d  = '{out_word: pword,
                       out_valid_bytes: rd_last ? vb_q : 3'd4,
                       out_end_of_frame: rd_last};
        end
        if (rd_issue) begin
          rd_ptr_d  = rd_ptr_q + CW'(1);
          rd_pend_d = 1'b1;
        end else if (rd_load) begin
          rd_pend_d = 1'b0;
        end
        if (!rd_pend_q && (rd_ptr_q == cnt_q)) begin
          cnt_d   = '0;
          state_d = eof_q ? StHold : StPass;
        end
      end
      StPass: begin
        if (pass_fire) begin
          ovalid_d = 1'b1;
          obeat_d  = '{out_word: w, out_valid_bytes: vbn, out_end_of_frame: eof};
          if (eof) state_d = StHold;
        end
      end
      default: state_d = StHold;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StHold;
      cnt_q     <= '0;
      rd_ptr_q  <= '0;
      rd_pend_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_pend_q <= rd_pend_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obeat_q <= obeat_d;
    acc_q   <= acc_d;
    if (rd_issue) rd_idx_q <= rd_ptr_q;
    if (state_q == StFold) csum_q <= ~fold2;
    if (hold_fire) begin
      if (is3) hdr_q <= w[31:8];
      if (cnt_q == CW'(WordDstLo))  x34_q <= w[15:0];
      if (cnt_q == CW'(WordHidden)) x36_q <= w[31:16];
      if (rel_now) begin
        eof_q <= eof;
        vb_q  <= vbn;
        rew_q <= rew_now;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_beat_o  = obeat_q;

endmodule
